// ----- rtl/core/wbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared constants, codes and width helpers of the white blob steering block.
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned FW_W      = 13;
  localparam int unsigned SPD_W     = 14;
  localparam int unsigned CLS_W     = 3;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned COL_OUT_W = 12;
  localparam int unsigned FRAC_W    = 14;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PIX_W-1:0] PIX_WHITE         = 8'hFF;
  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST   = 13'd640;
  localparam logic [SPD_W-1:0] FORWARD_SPEED_RST = 14'd4915;
  localparam int unsigned      LEFT_RST          = 4095;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_SPEED = 1'b1;

  localparam logic [CLS_W-1:0] CLS_NONE   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LEFT   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_RIGHT  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_CLOSE  = 3'd3;
  localparam logic [CLS_W-1:0] CLS_CENTER = 3'd4;

  // column counter width
  function automatic int unsigned col_w(int unsigned max_width);
    return $clog2(max_width);
  endfunction

  // extent register width, wide enough for the all-ones reset value
  function automatic int unsigned ext_w(int unsigned max_width);
    int unsigned cw;
    cw = $clog2(max_width);
    return (cw > COL_OUT_W) ? cw : COL_OUT_W;
  endfunction

endpackage

// ----- rtl/core/white_blob_steering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_blob_steering
// Tracks the column extent of pure-white pixels over a frame and turns it
// into a position class, a forward speed and a turn rate at frame end.
// ----------------------------------------------------------------------------
// Pixel words are taken one per clock while the input is ready. A word
// marked frame_end starts the frame-end sequencer, and the input is not
// ready until the sequencer is back in idle; when a turn is needed it also
// runs the turn-rate division, one quotient bit per cycle through the single
// shared subtractor. The result sits in an output register, so pixels of the
// next frame are taken while it waits; only the next frame end then waits
// for the result to be taken. Configuration writes are taken on every clock.
module white_blob_steering #(
  parameter int unsigned MAX_WIDTH = wbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [wbs_pkg::PIX_W-1:0]            red_i,
  input  logic [wbs_pkg::PIX_W-1:0]            green_i,
  input  logic [wbs_pkg::PIX_W-1:0]            blue_i,
  input  logic                                 frame_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [wbs_pkg::CLS_W-1:0]            position_class_o,
  output logic [wbs_pkg::SPD_W-1:0]            linear_speed_o,
  output logic signed [wbs_pkg::ANG_W-1:0]     angular_rate_o,
  output logic [wbs_pkg::COL_OUT_W-1:0]        left_column_o,
  output logic [wbs_pkg::COL_OUT_W-1:0]        right_column_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wbs_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [wbs_pkg::SPD_W-1:0]            cfg_data_i
);

  localparam int unsigned LW = wbs_pkg::ext_w(MAX_WIDTH);

  logic [wbs_pkg::FW_W-1:0]  frame_width_q, frame_width_d, eff_width;
  logic [wbs_pkg::SPD_W-1:0] forward_speed_q, forward_speed_d;
  logic [LW-1:0]             ext_left, ext_right;
  logic                      ext_seen, busy, pix_accept, start;
  logic [wbs_pkg::ANG_W-1:0] ang;

  always_comb begin
    frame_width_d   = frame_width_q;
    forward_speed_d = forward_speed_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wbs_pkg::CFG_FRAME_WIDTH:   frame_width_d   = cfg_data_i[wbs_pkg::FW_W-1:0];
        wbs_pkg::CFG_FORWARD_SPEED: forward_speed_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= wbs_pkg::FRAME_WIDTH_RST;
      forward_speed_q <= wbs_pkg::FORWARD_SPEED_RST;
    end else begin
      frame_width_q   <= frame_width_d;
      forward_speed_q <= forward_speed_d;
    end
  end

  // zero acts as one, above the limit acts as the limit
  always_comb begin
    priority if (frame_width_q == '0) begin
      eff_width = wbs_pkg::FW_W'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_width = wbs_pkg::FW_W'(MAX_WIDTH);
    end else begin
      eff_width = frame_width_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~busy;
  assign pix_accept  = in_valid_i & in_ready_o;
  assign start       = pix_accept & frame_end_i;

  wbs_extent #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_wbs_extent (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_accept_i (pix_accept),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .frame_end_i  (frame_end_i),
    .width_i      (eff_width),
    .left_o       (ext_left),
    .right_o      (ext_right),
    .seen_o       (ext_seen)
  );

  wbs_seq #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_wbs_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .left_i      (ext_left),
    .right_i     (ext_right),
    .seen_i      (ext_seen),
    .width_i     (eff_width),
    .speed_i     (forward_speed_q),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cls_o       (position_class_o),
    .lin_o       (linear_speed_o),
    .ang_o       (ang),
    .lc_o        (left_column_o),
    .rc_o        (right_column_o)
  );

  assign angular_rate_o = $signed(ang);

endmodule

// ----- rtl/core/wbs_sub.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_sub
// Shared subtract and compare unit used by the frame-end sequencer.
// ----------------------------------------------------------------------------
module wbs_sub #(
  parameter int unsigned W = 15
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         borrow_o
);

  assign {borrow_o, diff_o} = {1'b0, a_i} - {1'b0, b_i};

endmodule

// ----- rtl/core/wbs_extent.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_extent
// Column tracker and white column extent, one pixel word per clock when accepted.
// ----------------------------------------------------------------------------
module wbs_extent #(
  parameter int unsigned MAX_WIDTH = wbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     pix_accept_i,
  input  logic [wbs_pkg::PIX_W-1:0]                red_i,
  input  logic [wbs_pkg::PIX_W-1:0]                green_i,
  input  logic [wbs_pkg::PIX_W-1:0]                blue_i,
  input  logic                                     frame_end_i,
  input  logic [wbs_pkg::FW_W-1:0]                 width_i,
  output logic [wbs_pkg::ext_w(MAX_WIDTH)-1:0]     left_o,
  output logic [wbs_pkg::ext_w(MAX_WIDTH)-1:0]     right_o,
  output logic                                     seen_o
);

  localparam int unsigned CW = wbs_pkg::col_w(MAX_WIDTH);
  localparam int unsigned LW = wbs_pkg::ext_w(MAX_WIDTH);
  localparam int unsigned NW = ((CW > wbs_pkg::FW_W) ? CW : wbs_pkg::FW_W) + 1;

  logic [CW-1:0] col_q, col_d;
  logic [LW-1:0] left_q, left_d, left_nx;
  logic [LW-1:0] right_q, right_d, right_nx;
  logic          seen_q, seen_d, seen_nx;
  logic [NW-1:0] col_inc;
  logic          white;

  always_comb begin
    white = (red_i == wbs_pkg::PIX_WHITE) && (green_i == wbs_pkg::PIX_WHITE) &&
            (blue_i == wbs_pkg::PIX_WHITE);
    left_nx  = left_q;
    right_nx = right_q;
    seen_nx  = seen_q;
    if (white) begin
      if (LW'(col_q) < left_q) begin
        left_nx = LW'(col_q);
      end
      if (LW'(col_q) > right_q) begin
        right_nx = LW'(col_q);
      end
      seen_nx = 1'b1;
    end

    col_inc = NW'(col_q) + NW'(1);
    col_d   = col_q;
    left_d  = left_q;
    right_d = right_q;
    seen_d  = seen_q;
    if (pix_accept_i) begin
      if (frame_end_i) begin
        col_d   = '0;
        left_d  = LW'(wbs_pkg::LEFT_RST);
        right_d = '0;
        seen_d  = 1'b0;
      end else begin
        col_d   = (col_inc >= NW'(width_i)) ? '0 : CW'(col_inc);
        left_d  = left_nx;
        right_d = right_nx;
        seen_d  = seen_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      left_q  <= LW'(wbs_pkg::LEFT_RST);
      right_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      left_q  <= left_d;
      right_q <= right_d;
      seen_q  <= seen_d;
    end
  end

  assign left_o  = left_nx;
  assign right_o = right_nx;
  assign seen_o  = seen_nx;

endmodule

// ----- rtl/core/wbs_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_seq
// Frame-end sequencer: classification compares and restoring division,
// all through one shared subtractor, plus the result register.
// ----------------------------------------------------------------------------
module wbs_seq #(
  parameter int unsigned MAX_WIDTH = wbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [wbs_pkg::ext_w(MAX_WIDTH)-1:0]  left_i,
  input  logic [wbs_pkg::ext_w(MAX_WIDTH)-1:0]  right_i,
  input  logic                                  seen_i,
  input  logic [wbs_pkg::FW_W-1:0]              width_i,
  input  logic [wbs_pkg::SPD_W-1:0]             speed_i,
  output logic                                  busy_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [wbs_pkg::CLS_W-1:0]             cls_o,
  output logic [wbs_pkg::SPD_W-1:0]             lin_o,
  output logic [wbs_pkg::ANG_W-1:0]             ang_o,
  output logic [wbs_pkg::COL_OUT_W-1:0]         lc_o,
  output logic [wbs_pkg::COL_OUT_W-1:0]         rc_o
);

  localparam int unsigned LW    = wbs_pkg::ext_w(MAX_WIDTH);
  localparam int unsigned UW    = LW + 3;
  localparam int unsigned DVW   = UW + wbs_pkg::FRAC_W;
  localparam int unsigned CNT_W = $clog2(DVW);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_PREP = 4'd1;
  localparam logic [ST_W-1:0] ST_CMP0 = 4'd2;
  localparam logic [ST_W-1:0] ST_CMP1 = 4'd3;
  localparam logic [ST_W-1:0] ST_CMP2 = 4'd4;
  localparam logic [ST_W-1:0] ST_CMP3 = 4'd5;
  localparam logic [ST_W-1:0] ST_DIFF = 4'd6;
  localparam logic [ST_W-1:0] ST_NEG  = 4'd7;
  localparam logic [ST_W-1:0] ST_DIV  = 4'd8;
  localparam logic [ST_W-1:0] ST_FIN  = 4'd9;

  logic [ST_W-1:0] state_q, state_d;
  logic            out_valid_q, out_valid_d;

  logic [LW-1:0]                 l_q, l_d, r_q, r_d, mid_q, mid_d;
  logic [wbs_pkg::FW_W-1:0]      w_q, w_d;
  logic [wbs_pkg::SPD_W-1:0]     spd_q, spd_d;
  logic                          seen_q, seen_d;
  logic [UW-1:0]                 m5_q, m5_d, l5_q, l5_d, r5_q, r5_d, w2_q, w2_d, w3_q, w3_d;
  logic                          lt_q, lt_d, gt_q, gt_d, cl_q, cl_d, neg_q, neg_d;
  logic [wbs_pkg::CLS_W-1:0]     cls_q, cls_d;
  logic [DVW-1:0]                dvd_q, dvd_d;
  logic [UW-1:0]                 rem_q, rem_d, trial;
  logic [CNT_W-1:0]              cnt_q, cnt_d;

  logic [wbs_pkg::CLS_W-1:0]     ocls_q, ocls_d;
  logic [wbs_pkg::SPD_W-1:0]     olin_q, olin_d;
  logic [wbs_pkg::ANG_W-1:0]     oang_q, oang_d, quo;
  logic [wbs_pkg::COL_OUT_W-1:0] olc_q, olc_d, orc_q, orc_d;

  logic [LW:0]   mid_sum;
  logic [LW-1:0] mid_c;
  logic [UW-1:0] op_a, op_b, diff;
  logic          borrow, steer, moving;

  wbs_sub #(
    .W (UW)
  ) u_wbs_sub (
    .a_i      (op_a),
    .b_i      (op_b),
    .diff_o   (diff),
    .borrow_o (borrow)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    l_d   = l_q;   r_d   = r_q;   mid_d = mid_q;
    w_d   = w_q;   spd_d = spd_q; seen_d = seen_q;
    m5_d  = m5_q;  l5_d  = l5_q;  r5_d  = r5_q;  w2_d = w2_q; w3_d = w3_q;
    lt_d  = lt_q;  gt_d  = gt_q;  cl_d  = cl_q;  neg_d = neg_q;
    cls_d = cls_q; dvd_d = dvd_q; rem_d = rem_q; cnt_d = cnt_q;
    ocls_d = ocls_q; olin_d = olin_q; oang_d = oang_q; olc_d = olc_q; orc_d = orc_q;
    op_a  = '0;
    op_b  = '0;

    mid_sum = (LW+1)'(l_q) + (LW+1)'(r_q);
    mid_c   = LW'(mid_sum >> 1);
    trial   = {rem_q[UW-2:0], dvd_q[DVW-1]};
    quo     = dvd_q[wbs_pkg::ANG_W-1:0];
    steer   = (cls_q == wbs_pkg::CLS_LEFT) || (cls_q == wbs_pkg::CLS_RIGHT);
    moving  = steer || (cls_q == wbs_pkg::CLS_CENTER);

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          l_d     = left_i;
          r_d     = right_i;
          seen_d  = seen_i;
          w_d     = width_i;
          spd_d   = speed_i;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        mid_d   = mid_c;
        m5_d    = (UW'(mid_c) << 2) + UW'(mid_c);
        l5_d    = (UW'(l_q) << 2) + UW'(l_q);
        r5_d    = (UW'(r_q) << 2) + UW'(r_q);
        w2_d    = UW'(w_q) << 1;
        w3_d    = (UW'(w_q) << 1) + UW'(w_q);
        state_d = ST_CMP0;
      end
      ST_CMP0: begin
        op_a    = m5_q;
        op_b    = w2_q;
        lt_d    = borrow;
        state_d = ST_CMP1;
      end
      ST_CMP1: begin
        op_a    = w3_q;
        op_b    = m5_q;
        gt_d    = borrow;
        state_d = ST_CMP2;
      end
      ST_CMP2: begin
        op_a    = l5_q;
        op_b    = w2_q;
        cl_d    = borrow;
        state_d = ST_CMP3;
      end
      ST_CMP3: begin
        op_a  = w3_q;
        op_b  = r5_q;
        neg_d = 1'b0;
        priority if (!seen_q) begin
          cls_d   = wbs_pkg::CLS_NONE;
          state_d = ST_FIN;
        end else if (lt_q) begin
          cls_d   = wbs_pkg::CLS_LEFT;
          state_d = ST_DIFF;
        end else if (gt_q) begin
          cls_d   = wbs_pkg::CLS_RIGHT;
          state_d = ST_DIFF;
        end else if (cl_q && borrow) begin
          cls_d   = wbs_pkg::CLS_CLOSE;
          state_d = ST_FIN;
        end else begin
          cls_d   = wbs_pkg::CLS_CENTER;
          state_d = ST_FIN;
        end
      end
      ST_DIFF: begin
        op_a  = UW'(w_q);
        op_b  = UW'({mid_q, 1'b0});
        rem_d = '0;
        cnt_d = '0;
        if (borrow) begin
          neg_d   = 1'b1;
          state_d = ST_NEG;
        end else begin
          dvd_d   = {diff, wbs_pkg::FRAC_W'(0)};
          state_d = ST_DIV;
        end
      end
      ST_NEG: begin
        op_a    = UW'({mid_q, 1'b0});
        op_b    = UW'(w_q);
        dvd_d   = {diff, wbs_pkg::FRAC_W'(0)};
        state_d = ST_DIV;
      end
      ST_DIV: begin
        op_a  = trial;
        op_b  = UW'(w_q);
        rem_d = borrow ? trial : diff;
        dvd_d = {dvd_q[DVW-2:0], ~borrow};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ocls_d      = cls_q;
          olin_d      = moving ? spd_q : '0;
          oang_d      = steer ? (neg_q ? (~quo + wbs_pkg::ANG_W'(1)) : quo) : '0;
          olc_d       = seen_q ? l_q[wbs_pkg::COL_OUT_W-1:0] : '0;
          orc_d       = seen_q ? r_q[wbs_pkg::COL_OUT_W-1:0] : '0;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q   <= l_d;   r_q   <= r_d;   mid_q  <= mid_d;
    w_q   <= w_d;   spd_q <= spd_d; seen_q <= seen_d;
    m5_q  <= m5_d;  l5_q  <= l5_d;  r5_q   <= r5_d;  w2_q <= w2_d; w3_q <= w3_d;
    lt_q  <= lt_d;  gt_q  <= gt_d;  cl_q   <= cl_d;  neg_q <= neg_d;
    cls_q <= cls_d; dvd_q <= dvd_d; rem_q  <= rem_d; cnt_q <= cnt_d;
    ocls_q <= ocls_d; olin_q <= olin_d; oang_q <= oang_d; olc_q <= olc_d; orc_q <= orc_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cls_o       = ocls_q;
  assign lin_o       = olin_q;
  assign ang_o       = oang_q;
  assign lc_o        = olc_q;
  assign rc_o        = orc_q;

endmodule

// ----- rtl/core/wbs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbs_checker
// Port-level checks of the white blob steering block, bound to the top level.
// ----------------------------------------------------------------------------
module wbs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 frame_end_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [wbs_pkg::CLS_W-1:0]            position_class_o,
  input logic [wbs_pkg::SPD_W-1:0]            linear_speed_o,
  input logic signed [wbs_pkg::ANG_W-1:0]     angular_rate_o,
  input logic [wbs_pkg::COL_OUT_W-1:0]        left_column_o,
  input logic [wbs_pkg::COL_OUT_W-1:0]        right_column_o
);

  // stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_class_o) &&
      $stable(angular_rate_o) && $stable(linear_speed_o))
    else $error("stalled result word changed or dropped");

  // frame end hands the word to the sequencer
  a_busy_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && frame_end_i |=> !in_ready_o)
    else $error("input ready right after a frame-end word");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (position_class_o == wbs_pkg::CLS_NONE) |->
      linear_speed_o == '0 && angular_rate_o == '0 &&
      left_column_o == '0 && right_column_o == '0)
    else $error("no-blob result with nonzero fields");

  a_no_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (position_class_o == wbs_pkg::CLS_CLOSE ||
      position_class_o == wbs_pkg::CLS_CENTER) |-> angular_rate_o == '0)
    else $error("turn rate given for close or center");

  a_close_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (position_class_o == wbs_pkg::CLS_CLOSE) |-> linear_speed_o == '0)
    else $error("forward speed given for too close");

endmodule

bind white_blob_steering wbs_checker u_wbs_checker (.*);

// ----- tb/white_blob_steering_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_blob_steering_checker
// Watches the pixel, result and register channels of the white blob steering
// block, tracks the white column extent of each frame on its own, builds the
// steering command due at every frame end and compares it field by field
// with the command the block hands out.
// ----------------------------------------------------------------------------
module white_blob_steering_checker #(
  parameter int unsigned MAX_WIDTH = wbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [wbs_pkg::PIX_W-1:0]         red_i,
  input  logic [wbs_pkg::PIX_W-1:0]         green_i,
  input  logic [wbs_pkg::PIX_W-1:0]         blue_i,
  input  logic                              frame_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [wbs_pkg::CLS_W-1:0]         position_class_i,
  input  logic [wbs_pkg::SPD_W-1:0]         linear_speed_i,
  input  logic signed [wbs_pkg::ANG_W-1:0]  angular_rate_i,
  input  logic [wbs_pkg::COL_OUT_W-1:0]     left_column_i,
  input  logic [wbs_pkg::COL_OUT_W-1:0]     right_column_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [wbs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wbs_pkg::SPD_W-1:0]         cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import wbs_pkg::*;

  typedef struct packed {
    logic [CLS_W-1:0]     cls;
    logic [SPD_W-1:0]     speed;
    logic [ANG_W-1:0]     turn;
    logic [COL_OUT_W-1:0] left;
    logic [COL_OUT_W-1:0] right;
  } steer_cmd_t;

  logic [FW_W-1:0]  width_reg;
  logic [SPD_W-1:0] speed_reg;
  int unsigned      column;
  int unsigned      leftmost;
  int unsigned      rightmost;
  bit               blob_seen;
  steer_cmd_t       due_cmds[$];
  int               errors = 0;

  function automatic int unsigned active_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  task automatic clear_extent();
    column    = 0;
    leftmost  = LEFT_RST;
    rightmost = 0;
    blob_seen = 1'b0;
  endtask

  task automatic track_pixel(input logic [PIX_W-1:0] r, g, b, input logic last);
    int unsigned w;
    int unsigned mid;
    longint      diff;
    longint      q;
    steer_cmd_t  cmd;
    w = active_width();
    if (r == PIX_WHITE && g == PIX_WHITE && b == PIX_WHITE) begin
      if (column < leftmost) leftmost = column;
      if (column > rightmost) rightmost = column;
      blob_seen = 1'b1;
    end
    column = (column + 1 >= w) ? 0 : column + 1;
    if (!last) return;
    cmd = '0;
    cmd.cls = CLS_NONE;
    if (blob_seen) begin
      mid = (leftmost + rightmost) / 2;
      cmd.left  = leftmost[COL_OUT_W-1:0];
      cmd.right = rightmost[COL_OUT_W-1:0];
      if (5 * mid < 2 * w || 5 * mid > 3 * w) begin
        diff = longint'(w) - 2 * longint'(mid);
        q = (diff * 16384) / longint'(w);
        cmd.cls   = (5 * mid < 2 * w) ? CLS_LEFT : CLS_RIGHT;
        cmd.speed = speed_reg;
        cmd.turn  = q[ANG_W-1:0];
      end else if (5 * leftmost < 2 * w && 5 * rightmost > 3 * w) begin
        cmd.cls = CLS_CLOSE;
      end else begin
        cmd.cls   = CLS_CENTER;
        cmd.speed = speed_reg;
      end
    end
    due_cmds.push_back(cmd);
    clear_extent();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_cmd_t want;
    if (!rst_ni) begin
      width_reg = FRAME_WIDTH_RST;
      speed_reg = FORWARD_SPEED_RST;
      clear_extent();
      due_cmds.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (in_valid_i && in_ready_i) begin
        track_pixel(red_i, green_i, blue_i, frame_end_i);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) width_reg = cfg_data_i[FW_W-1:0];
        else if (cfg_index_i == CFG_FORWARD_SPEED) speed_reg = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (due_cmds.size() == 0) begin
          $error("unexpected result word: position_class %0d", position_class_i);
          errors++;
        end else begin
          want = due_cmds.pop_front();
          check_field("position_class", want.cls, position_class_i);
          check_field("linear_speed", want.speed, linear_speed_i);
          check_field("angular_rate", longint'($signed(want.turn)),
                      longint'(angular_rate_i));
          check_field("left_column", want.left, left_column_i);
          check_field("right_column", want.right, right_column_i);
        end
      end
      pending_o    <= due_cmds.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ----- tb/white_blob_steering_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// white_blob_steering_tb
// Drives pixel frames and register writes into the white blob steering block
// with random gaps and output stalls: a short directed set covering every
// position class and the width corner cases, then random frames with random
// widths, blobs, near-white noise, odd frame lengths and unfinished frames.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module white_blob_steering_tb;
  import wbs_pkg::*;

  localparam int unsigned PIXEL_TARGET = 1750;
  localparam int unsigned CALM_TAIL    = 250;
  localparam int unsigned SETTLE       = 60;
  localparam int unsigned QUIET_LIMIT  = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      red;
  logic [PIX_W-1:0]      green;
  logic [PIX_W-1:0]      blue;
  logic                  frame_end;
  logic                  out_valid;
  logic                  out_ready;
  logic [CLS_W-1:0]      position_class;
  logic [SPD_W-1:0]      linear_speed;
  logic signed [ANG_W-1:0] angular_rate;
  logic [COL_OUT_W-1:0]  left_column;
  logic [COL_OUT_W-1:0]  right_column;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SPD_W-1:0]      cfg_data;

  int          fail_count;
  int          pending;
  int unsigned pixels_sent = 0;
  int unsigned cur_width = FRAME_WIDTH_RST;
  bit          calm = 1'b0;
  int unsigned quiet = 0;
  int unsigned stall_left = 0;

  white_blob_steering uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .red_i            (red),
    .green_i          (green),
    .blue_i           (blue),
    .frame_end_i      (frame_end),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .position_class_o (position_class),
    .linear_speed_o   (linear_speed),
    .angular_rate_o   (angular_rate),
    .left_column_o    (left_column),
    .right_column_o   (right_column),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  white_blob_steering_checker steer_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .red_i            (red),
    .green_i          (green),
    .blue_i           (blue),
    .frame_end_i      (frame_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .position_class_i (position_class),
    .linear_speed_i   (linear_speed),
    .angular_rate_i   (angular_rate),
    .left_column_i    (left_column),
    .right_column_i   (right_column),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 14);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic last);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    red       = r;
    green     = g;
    blue      = b;
    frame_end = last;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // stop the pixel stream, let all results drain and the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPD_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_width(input logic [SPD_W-1:0] data);
    write_reg(CFG_FRAME_WIDTH, data);
    cur_width = data[FW_W-1:0];
    if (cur_width == 0) cur_width = 1;
    if (cur_width > MAX_WIDTH_DEF) cur_width = MAX_WIDTH_DEF;
  endtask

  task automatic send_frame(input bit with_end);
    int unsigned span;
    int unsigned len;
    int unsigned reach;
    int unsigned lo;
    int unsigned hi;
    int unsigned col;
    int unsigned pick;
    logic [PIX_W-1:0] r, g, b, val;
    bit blob;
    span  = (cur_width <= 64) ? cur_width * $urandom_range(1, 3) : $urandom_range(1, 120);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span) : span;
    reach = (cur_width <= 64) ? cur_width : len;
    lo    = $urandom_range(0, reach - 1);
    hi    = $urandom_range(lo, reach - 1);
    blob  = $urandom_range(0, 4) != 0;
    for (int unsigned k = 0; k < len; k++) begin
      col = k % cur_width;
      if (blob && col >= lo && col <= hi && $urandom_range(0, 3) != 0) begin
        r = PIX_WHITE;
        g = PIX_WHITE;
        b = PIX_WHITE;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            r = '0;
            g = '0;
            b = '0;
          end
          1: begin
            // one channel short of white
            r = PIX_WHITE;
            g = PIX_WHITE;
            b = PIX_WHITE;
            val  = $urandom_range(0, 254);
            pick = $urandom_range(0, 2);
            if (pick == 0) r = val;
            else if (pick == 1) g = val;
            else b = val;
          end
          default: begin
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
          end
        endcase
      end
      send_pixel(r, g, b, with_end && (k == len - 1));
    end
  endtask

  initial begin
    logic [4:0] marks[3];
    in_valid  = 1'b0;
    red       = '0;
    green     = '0;
    blue      = '0;
    frame_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data  = '0;
    rst_n     = 1'b0;
    marks[0]  = 5'b10000;
    marks[1]  = 5'b10001;
    marks[2]  = 5'b00100;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: empty frame, blob at column zero, near-white only
    send_pixel('0, '0, '0, 1'b1);
    send_pixel(PIX_WHITE, PIX_WHITE, PIX_WHITE, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h01, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'hFF, 1'b1);

    // five columns: right, too close, center
    settle();
    set_width(14'd5);
    write_reg(CFG_FORWARD_SPEED, 14'h3FFF);
    for (int f = 0; f < 3; f++) begin
      for (int k = 0; k < 5; k++) begin
        if (marks[f][k]) send_pixel(PIX_WHITE, PIX_WHITE, PIX_WHITE, k == 4);
        else send_pixel(8'h10, 8'h20, 8'h30, k == 4);
      end
    end

    // zero width acts as one, zero speed
    settle();
    set_width(14'd0);
    write_reg(CFG_FORWARD_SPEED, 14'd0);
    send_pixel(PIX_WHITE, PIX_WHITE, PIX_WHITE, 1'b1);

    // width above the maximum is clamped
    settle();
    set_width(14'h1FFF);
    send_pixel('0, '0, '0, 1'b0);
    send_pixel(PIX_WHITE, PIX_WHITE, PIX_WHITE, 1'b1);

    while (pixels_sent < PIXEL_TARGET) begin
      calm = pixels_sent + CALM_TAIL >= PIXEL_TARGET;
      settle();
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 19))
          0:       set_width({1'($urandom_range(0, 1)), 13'd0});
          1:       set_width({1'($urandom_range(0, 1)), 13'h1FFF});
          2:       set_width(14'd4097);
          3:       set_width(14'd4096);
          4:       set_width(14'($urandom_range(65, 130)));
          default: set_width({1'($urandom_range(0, 1)), 13'($urandom_range(1, 16))});
        endcase
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_FORWARD_SPEED, 14'd0);
          1:       write_reg(CFG_FORWARD_SPEED, 14'h3FFF);
          default: write_reg(CFG_FORWARD_SPEED, 14'($urandom_range(0, 16383)));
        endcase
      end
      repeat ($urandom_range(1, 4)) send_frame(1'b1);
      // unfinished frame, the next width write lands mid-frame
      if ($urandom_range(0, 6) == 0) send_frame(1'b0);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
